// File: sv/casp_pkg.sv
// Shared types, constants and fixed-point helpers of the cascaded angle/speed PID.
`default_nettype none
package casp_pkg;

    localparam int GAIN_W  = 24;
    localparam int ENC_W   = 13;
    localparam int W_W     = 17;
    localparam int ANG_W   = 25;
    localparam int MUL_A_W = 25;
    localparam int MUL_B_W = 34;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int SHR_W   = PROD_W - 16;
    localparam int ACC_W   = 50;

    localparam logic signed [ANG_W-1:0] DEG_PER_COUNT = 25'sd2880;
    localparam logic signed [26:0] HALF_TURN_Q   = 27'sd11796480;
    localparam logic signed [26:0] FULL_TURN_Q   = 27'sd23592960;
    localparam logic signed [ANG_W-1:0] HOMED_LIM_Q = 25'sd196608;
    localparam logic signed [43:0] ANGLE_I_LIM_Q = 44'sd2621440;
    localparam logic signed [43:0] SPEED_I_LIM_Q = 44'sd196608000;
    localparam logic signed [ACC_W-1:0] SPEED_TGT_LIM_Q = 50'sd16384000;
    localparam logic signed [ACC_W-1:0] VOLT_LIM_Q      = 50'sd1638400000;
    localparam logic [W_W-1:0] Q_ONE = 17'd65536;

    typedef enum logic [2:0] {
        REG_ZERO_POSITION = 3'd0,
        REG_ANGLE_P_GAIN  = 3'd1,
        REG_ANGLE_I_GAIN  = 3'd2,
        REG_ANGLE_D_GAIN  = 3'd3,
        REG_SPEED_P_GAIN  = 3'd4,
        REG_SPEED_I_GAIN  = 3'd5,
        REG_SPEED_D_GAIN  = 3'd6,
        REG_FILTER_WEIGHT = 3'd7
    } casp_reg_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_ANGLE, ST_ERR,
        ST_FW_MUL, ST_FW_USE, ST_FF_MUL, ST_FF_USE, ST_FILT,
        ST_AP_MUL, ST_AP_USE, ST_AI_MUL, ST_AI_USE, ST_AD_MUL, ST_AD_USE,
        ST_TGT, ST_SERR,
        ST_SP_MUL, ST_SP_USE, ST_SI_MUL, ST_SI_USE, ST_SD_MUL, ST_SD_USE,
        ST_VOLT, ST_DONE
    } casp_state_t;

    typedef struct packed {
        logic        load;
        casp_state_t op;
        logic        out_load;
    } casp_cmd_t;

    // Shift right by 16 with truncation toward zero.
    function automatic logic signed [SHR_W-1:0] shr_q(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] r;
        r = p + (p[PROD_W-1] ? PROD_W'(17'h0FFFF) : '0);
        return r[PROD_W-1:16];
    endfunction

endpackage
`default_nettype wire

// File: sv/casp_ctrl.sv
// Sequencer of the control tick: steps the datapath and runs the handshakes.
`default_nettype none
module casp_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output casp_pkg::casp_cmd_t     cmd
);
    import casp_pkg::*;

    casp_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd.load     = 1'b0;
        cmd.op       = state_reg;
        cmd.out_load = 1'b0;
        s_ready      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_ANGLE;
                end
            end
            ST_DONE: begin
                // hold the finished word until the output slot frees
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = casp_state_t'(state_reg + 5'd1);
        endcase
        m_valid_next = (m_valid_reg && !m_ready) || cmd.out_load;
    end

    assign m_valid = m_valid_reg;

endmodule
`default_nettype wire

// File: sv/casp_dp.sv
// Datapath: configuration registers, loop state, shared multiplier and accumulator.
`default_nettype none
module casp_dp (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire logic [2:0]                   cfg_index,
    input  wire logic [23:0]                  cfg_wr_data,
    input  wire casp_pkg::casp_cmd_t          cmd,
    input  wire logic [12:0]                  s_encoder_angle,
    input  wire logic signed [15:0]           s_rotor_speed,
    input  wire logic signed [24:0]           s_target_angle,
    input  wire logic signed [24:0]           s_speed_feedforward,
    output logic signed [15:0]                m_drive_voltage,
    output logic signed [24:0]                m_tracking_error,
    output logic                              m_homed
);
    import casp_pkg::*;

    logic [ENC_W-1:0]  zero_pos_reg;
    logic [GAIN_W-1:0] kap_reg, kai_reg, kad_reg, ksp_reg, ksi_reg, ksd_reg;
    logic [W_W-1:0]    fw_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_pos_reg <= '0;
            kap_reg      <= 24'd393216;
            kai_reg      <= 24'd3277;
            kad_reg      <= 24'd26214;
            ksp_reg      <= 24'd6553600;
            ksi_reg      <= 24'd32768;
            ksd_reg      <= 24'd19661;
            fw_reg       <= 17'd52429;
        end else if (cfg_wr_en) begin
            case (casp_reg_t'(cfg_index))
                REG_ZERO_POSITION: zero_pos_reg <= cfg_wr_data[ENC_W-1:0];
                REG_ANGLE_P_GAIN:  kap_reg <= cfg_wr_data;
                REG_ANGLE_I_GAIN:  kai_reg <= cfg_wr_data;
                REG_ANGLE_D_GAIN:  kad_reg <= cfg_wr_data;
                REG_SPEED_P_GAIN:  ksp_reg <= cfg_wr_data;
                REG_SPEED_I_GAIN:  ksi_reg <= cfg_wr_data;
                REG_SPEED_D_GAIN:  ksd_reg <= cfg_wr_data;
                REG_FILTER_WEIGHT: fw_reg  <= cfg_wr_data[W_W-1:0];
                default: ;
            endcase
        end
    end

    // latched word and working registers
    logic [ENC_W-1:0]         enc_reg;
    logic signed [15:0]       spd_reg;
    logic signed [ANG_W-1:0]  tgt_reg, ff_reg, angle_reg, err_reg;
    logic                     homed_reg;
    logic signed [31:0]       filt_reg, a_last_reg, a_int_reg, s_last_reg, s_int_reg;
    logic                     primed_reg;
    logic signed [31:0]       serr_reg;
    logic signed [MUL_B_W-1:0] dif_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [15:0]       drive_reg;

    // encoder count to degrees
    logic signed [13:0] diff_raw, diff_w;
    logic signed [ANG_W-1:0] angle_next;
    always_comb begin
        diff_raw = $signed({1'b0, enc_reg}) - $signed({1'b0, zero_pos_reg});
        if (diff_raw > 14'sd4096)       diff_w = diff_raw - 14'sd8192;
        else if (diff_raw < -14'sd4096) diff_w = diff_raw + 14'sd8192;
        else                            diff_w = diff_raw;
        angle_next = ANG_W'(diff_w) * DEG_PER_COUNT;
    end

    // wrapped angle error
    logic signed [26:0] err_raw, err_w;
    always_comb begin
        err_raw = 27'(tgt_reg) - 27'(angle_reg);
        if (err_raw > HALF_TURN_Q)       err_w = err_raw - FULL_TURN_Q;
        else if (err_raw < -HALF_TURN_Q) err_w = err_raw + FULL_TURN_Q;
        else                             err_w = err_raw;
    end

    // shared multiplier operands
    logic [W_W-1:0]            w_sat;
    logic [MUL_A_W-1:0]        mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    always_comb begin
        w_sat = (fw_reg > Q_ONE) ? Q_ONE : fw_reg;
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            ST_FW_MUL: begin
                mul_a = MUL_A_W'(w_sat);
                mul_b = MUL_B_W'($signed({spd_reg, 16'h0000}));
            end
            ST_FF_MUL: begin
                mul_a = MUL_A_W'(Q_ONE - w_sat);
                mul_b = MUL_B_W'(filt_reg);
            end
            ST_AP_MUL: begin mul_a = MUL_A_W'(kap_reg); mul_b = MUL_B_W'(err_reg); end
            ST_AI_MUL: begin mul_a = MUL_A_W'(kai_reg); mul_b = MUL_B_W'(err_reg); end
            ST_AD_MUL: begin mul_a = MUL_A_W'(kad_reg); mul_b = dif_reg; end
            ST_SP_MUL: begin mul_a = MUL_A_W'(ksp_reg); mul_b = MUL_B_W'(serr_reg); end
            ST_SI_MUL: begin mul_a = MUL_A_W'(ksi_reg); mul_b = MUL_B_W'(serr_reg); end
            ST_SD_MUL: begin mul_a = MUL_A_W'(ksd_reg); mul_b = dif_reg; end
            default: ;
        endcase
    end

    logic signed [SHR_W-1:0]  term;
    logic signed [ACC_W-1:0]  term_x;
    logic signed [43:0]       a_sum, s_sum;
    logic signed [31:0]       a_int_c, s_int_c;
    logic signed [ACC_W-1:0]  acc_c250, volt_c;
    logic signed [ACC_W:0]    serr_raw;
    logic signed [31:0]       serr_sat;
    logic signed [SHR_W-1:0]  filt_q, volt_q;
    always_comb begin
        term   = shr_q(prod_reg);
        term_x = ACC_W'(term);
        a_sum  = 44'(a_int_reg) + 44'(term);
        s_sum  = 44'(s_int_reg) + 44'(term);
        if (a_sum > ANGLE_I_LIM_Q)       a_int_c = 32'(ANGLE_I_LIM_Q);
        else if (a_sum < -ANGLE_I_LIM_Q) a_int_c = 32'(-ANGLE_I_LIM_Q);
        else                             a_int_c = 32'(a_sum);
        if (s_sum > SPEED_I_LIM_Q)       s_int_c = 32'(SPEED_I_LIM_Q);
        else if (s_sum < -SPEED_I_LIM_Q) s_int_c = 32'(-SPEED_I_LIM_Q);
        else                             s_int_c = 32'(s_sum);
        if (acc_reg > SPEED_TGT_LIM_Q)       acc_c250 = SPEED_TGT_LIM_Q;
        else if (acc_reg < -SPEED_TGT_LIM_Q) acc_c250 = -SPEED_TGT_LIM_Q;
        else                                 acc_c250 = acc_reg;
        if (acc_reg > VOLT_LIM_Q)       volt_c = VOLT_LIM_Q;
        else if (acc_reg < -VOLT_LIM_Q) volt_c = -VOLT_LIM_Q;
        else                            volt_c = acc_reg;
        serr_raw = (ACC_W+1)'(acc_reg) - (ACC_W+1)'(filt_reg);
        if (serr_raw > (ACC_W+1)'(32'sh7FFFFFFF))       serr_sat = 32'sh7FFFFFFF;
        else if (serr_raw < -(ACC_W+1)'(33'sh80000000)) serr_sat = 32'sh80000000;
        else                                            serr_sat = 32'(serr_raw);
        filt_q = shr_q(PROD_W'(acc_reg));
        volt_q = shr_q(PROD_W'(volt_c));
    end

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'($signed(mul_a) * mul_b);
        if (cmd.load) begin
            enc_reg <= s_encoder_angle;
            spd_reg <= s_rotor_speed;
            tgt_reg <= s_target_angle;
            ff_reg  <= s_speed_feedforward;
        end
        case (cmd.op)
            ST_ANGLE:  angle_reg <= angle_next;
            ST_ERR: begin
                err_reg   <= ANG_W'(err_w);
                homed_reg <= (angle_reg < HOMED_LIM_Q) && (angle_reg > -HOMED_LIM_Q);
            end
            ST_FW_USE: acc_reg <= prod_reg[ACC_W-1:0];
            ST_FF_USE: acc_reg <= acc_reg + prod_reg[ACC_W-1:0];
            ST_AP_USE: begin
                acc_reg <= term_x + ACC_W'(ff_reg);
                dif_reg <= MUL_B_W'(err_reg) - MUL_B_W'(a_last_reg);
            end
            ST_AD_MUL: acc_reg <= acc_reg + ACC_W'(a_int_reg);
            ST_AD_USE: acc_reg <= acc_reg + term_x;
            ST_TGT:    acc_reg <= acc_c250;
            ST_SERR:   serr_reg <= serr_sat;
            ST_SP_USE: begin
                acc_reg <= term_x;
                dif_reg <= MUL_B_W'(serr_reg) - MUL_B_W'(s_last_reg);
            end
            ST_SD_MUL: acc_reg <= acc_reg + ACC_W'(s_int_reg);
            ST_SD_USE: acc_reg <= acc_reg + term_x;
            ST_VOLT:   drive_reg <= volt_q[15:0];
            default: ;
        endcase
        if (cmd.out_load) begin
            m_drive_voltage  <= drive_reg;
            m_tracking_error <= err_reg;
            m_homed          <= homed_reg;
        end
    end

    // loop state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filt_reg   <= '0;
            primed_reg <= 1'b0;
            a_last_reg <= '0;
            a_int_reg  <= '0;
            s_last_reg <= '0;
            s_int_reg  <= '0;
        end else begin
            case (cmd.op)
                ST_FILT: begin
                    // seed from the first sample
                    filt_reg   <= primed_reg ? filt_q[31:0] : 32'({spd_reg, 16'h0000});
                    primed_reg <= 1'b1;
                end
                ST_AI_USE: a_int_reg  <= a_int_c;
                ST_AD_MUL: a_last_reg <= 32'(err_reg);
                ST_SI_USE: s_int_reg  <= s_int_c;
                ST_SD_MUL: s_last_reg <= serr_reg;
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: sv/cascaded_angle_speed_pid_unit.sv
// Top level of the cascaded angle/speed PID: sequencer plus datapath.
//
// One input word is one control tick: encoder count, raw speed, target angle
// and speed feedforward go in on the s_ channel (valid/ready); the drive
// voltage, wrapped tracking error and homed flag come out on the m_ channel.
// The configuration port writes a register on any edge with cfg_wr_en high;
// write it only while the block is idle.
// The block takes a new word only when the tick before it has finished: the
// eight products of the tick go through one shared multiplier, each followed
// by an accumulate step.
// A new word is accepted while a finished result still waits on m_; if the
// receiver stalls longer, the next tick holds in its last step until the
// output register frees.
// Reset clears the speed filter (first sample seeds it), both integrals and
// both last errors, and loads the default gains and zero position.
`default_nettype none
module cascaded_angle_speed_pid_unit (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [23:0]        cfg_wr_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [12:0]        s_encoder_angle,
    input  wire logic signed [15:0] s_rotor_speed,
    input  wire logic signed [24:0] s_target_angle,
    input  wire logic signed [24:0] s_speed_feedforward,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [15:0]      m_drive_voltage,
    output logic signed [24:0]      m_tracking_error,
    output logic                    m_homed
);
    import casp_pkg::*;

    casp_cmd_t cmd;

    casp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    casp_dp u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_index           (cfg_index),
        .cfg_wr_data         (cfg_wr_data),
        .cmd                 (cmd),
        .s_encoder_angle     (s_encoder_angle),
        .s_rotor_speed       (s_rotor_speed),
        .s_target_angle      (s_target_angle),
        .s_speed_feedforward (s_speed_feedforward),
        .m_drive_voltage     (m_drive_voltage),
        .m_tracking_error    (m_tracking_error),
        .m_homed             (m_homed)
    );

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a tick is in progress");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not idle after reset");

    a_volt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_drive_voltage <= 16'sd25000) && (m_drive_voltage >= -16'sd25000))
        else $error("drive voltage beyond saturation");

    a_err_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_tracking_error <= 25'sd11796480)
                    && (m_tracking_error >= -25'sd11796480))
        else $error("tracking error not wrapped");

endmodule
`default_nettype wire

// File: sim/cascaded_angle_speed_pid_unit_tb.sv
// Self-checking bench for the cascaded angle/speed PID unit with a fixed-point tick predictor.
`default_nettype none
module cascaded_angle_speed_pid_unit_tb;
    import casp_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_WAIT  = 40;
    localparam int LONG_HOLD   = 400;

    typedef struct {
        logic signed [15:0] voltage;
        logic signed [24:0] error;
        logic               homed;
    } tick_result_t;

    class tick_tracker;
        longint       regs [8];
        int           reg_bits [8];
        int           filt_speed;
        bit           primed;
        int           ang_last;
        int           ang_integ;
        int           spd_last;
        int           spd_integ;
        tick_result_t expected_ticks [$];
        int           mismatches;

        function new();
            reg_bits = '{13, 24, 24, 24, 24, 24, 24, 17};
            regs = '{0, 393216, 3277, 26214, 6553600, 32768, 19661, 52429};
            filt_speed = 0;
            primed = 0;
            ang_last = 0;
            ang_integ = 0;
            spd_last = 0;
            spd_integ = 0;
            mismatches = 0;
        endfunction

        function void set_reg(int idx, longint val);
            regs[idx] = val & ((64'd1 << reg_bits[idx]) - 1);
        endfunction

        function longint shr16(longint v);
            if (v < 0) return -((-v) >>> 16);
            return v >>> 16;
        endfunction

        function longint clip(longint v, longint lim);
            if (v > lim) return lim;
            if (v < -lim) return -lim;
            return v;
        endfunction

        function int pending();
            return expected_ticks.size();
        endfunction

        // Advance the controller state by one tick and queue its result.
        function void note_tick(logic [12:0] enc, logic signed [15:0] spd,
                                logic signed [24:0] tgt, logic signed [24:0] ff);
            longint diff, angle, err, w, sq, p, acc, d, spd_tgt, serr, volt;
            tick_result_t r;
            diff = longint'(enc) - regs[REG_ZERO_POSITION];
            if (diff > 4096) diff -= 8192;
            else if (diff < -4096) diff += 8192;
            angle = diff * 2880;
            sq = longint'(spd) * 65536;
            if (!primed) begin
                filt_speed = int'(sq);
                primed = 1;
            end else begin
                w = regs[REG_FILTER_WEIGHT];
                if (w > 65536) w = 65536;
                filt_speed = int'(shr16(w * sq + (65536 - w) * longint'(filt_speed)));
            end
            err = longint'(tgt) - angle;
            if (err > 11796480) err -= 23592960;
            else if (err < -11796480) err += 23592960;

            p = shr16(regs[REG_ANGLE_P_GAIN] * err);
            acc = clip(longint'(ang_integ) + shr16(regs[REG_ANGLE_I_GAIN] * err), 2621440);
            ang_integ = int'(acc);
            d = shr16(regs[REG_ANGLE_D_GAIN] * (err - longint'(ang_last)));
            ang_last = int'(err);
            spd_tgt = clip(p + acc + d + longint'(ff), 16384000);

            serr = spd_tgt - longint'(filt_speed);
            if (serr > 64'sd2147483647) serr = 64'sd2147483647;
            if (serr < -64'sd2147483648) serr = -64'sd2147483648;
            p = shr16(regs[REG_SPEED_P_GAIN] * serr);
            acc = clip(longint'(spd_integ) + shr16(regs[REG_SPEED_I_GAIN] * serr), 196608000);
            spd_integ = int'(acc);
            d = shr16(regs[REG_SPEED_D_GAIN] * (serr - longint'(spd_last)));
            spd_last = int'(serr);
            volt = clip(p + acc + d, 1638400000);

            r.voltage = 16'(shr16(volt));
            r.error = 25'(err);
            r.homed = (angle < 196608 && angle > -196608);
            expected_ticks.push_back(r);
        endfunction

        function void check_tick(logic signed [15:0] v, logic signed [24:0] e, logic h);
            tick_result_t x;
            if (expected_ticks.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: volt %0d err %0d homed %0b", v, e, h);
                return;
            end
            x = expected_ticks.pop_front();
            if (v !== x.voltage || e !== x.error || h !== x.homed) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: volt %0d/%0d err %0d/%0d homed %0b/%0b (exp/act)",
                             x.voltage, v, x.error, e, x.homed, h);
            end
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [2:0]         cfg_index;
    logic [23:0]        cfg_wr_data;
    logic               s_valid;
    logic               s_ready;
    logic [12:0]        s_encoder_angle;
    logic signed [15:0] s_rotor_speed;
    logic signed [24:0] s_target_angle;
    logic signed [24:0] s_speed_feedforward;
    logic               m_valid;
    logic               m_ready;
    logic signed [15:0] m_drive_voltage;
    logic signed [24:0] m_tracking_error;
    logic               m_homed;

    tick_tracker tracker;
    int          ready_mode;
    int          hold_requests;
    int          hold_served;
    int          hold_left;
    int          quiet_cycles;

    cascaded_angle_speed_pid_unit u_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_index           (cfg_index),
        .cfg_wr_data         (cfg_wr_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_encoder_angle     (s_encoder_angle),
        .s_rotor_speed       (s_rotor_speed),
        .s_target_angle      (s_target_angle),
        .s_speed_feedforward (s_speed_feedforward),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_drive_voltage     (m_drive_voltage),
        .m_tracking_error    (m_tracking_error),
        .m_homed             (m_homed)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Receiver stall pattern; a requested long hold overrides it.
    always @(negedge aclk) begin
        if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready = 1'b0;
        end else begin
            case (ready_mode)
                0: m_ready = 1'b1;
                1: m_ready = ($urandom_range(0, 3) != 0);
                default: m_ready = ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.check_tick(m_drive_voltage, m_tracking_error, m_homed);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_word(logic [12:0] enc, logic signed [15:0] spd,
                             logic signed [24:0] tgt, logic signed [24:0] ff);
        @(negedge aclk);
        s_valid = 1'b1;
        s_encoder_angle = enc;
        s_rotor_speed = spd;
        s_target_angle = tgt;
        s_speed_feedforward = ff;
        do @(posedge aclk); while (!s_ready);
        tracker.note_tick(enc, spd, tgt, ff);
    endtask

    task automatic pause_sender(int cycles);
        if (cycles > 0) begin
            @(negedge aclk);
            s_valid = 1'b0;
            repeat (cycles - 1) @(negedge aclk);
        end
    endtask

    task automatic drain();
        pause_sender(1);
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(casp_reg_t r, logic [23:0] val);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = r;
        cfg_wr_data = val;
        tracker.set_reg(int'(r), longint'(val));
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic send_random();
        logic [12:0]        enc;
        logic signed [15:0] spd;
        logic signed [24:0] tgt;
        logic signed [24:0] ff;
        enc = 13'($urandom);
        spd = 16'($urandom);
        if ($urandom_range(0, 9) == 0) begin
            tgt = 25'($urandom);
            ff = 25'($urandom);
        end else begin
            tgt = 25'(int'($urandom_range(0, 23592960)) - 11796480);
            ff = ($urandom_range(0, 2) == 0) ? 25'(int'($urandom_range(0, 32768000)) - 16384000)
                                             : 25'(int'($urandom_range(0, 2000000)) - 1000000);
            // hover near the zero point now and then
            if ($urandom_range(0, 4) == 0)
                enc = 13'(tracker.regs[REG_ZERO_POSITION] + $urandom_range(0, 140) - 70);
        end
        send_word(enc, spd, tgt, ff);
    endtask

    task automatic random_phase(int count, bit with_pressure);
        int sent;
        int burst;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 14);
            for (int k = 0; k < burst && sent < count; k++) begin
                send_random();
                sent++;
            end
            if (with_pressure && sent >= 20 && hold_requests == hold_served && hold_left == 0
                && sent < 30) begin
                hold_requests++;
                for (int k = 0; k < 8; k++) send_random();
                drain();
            end
            if ($urandom_range(0, 2) != 0)
                pause_sender($urandom_range(1, 30));
        end
    endtask

    initial begin
        tracker = new();
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_encoder_angle = '0;
        s_rotor_speed = '0;
        s_target_angle = '0;
        s_speed_feedforward = '0;
        m_ready = 1'b0;
        ready_mode = 0;
        hold_requests = 0;
        hold_served = 0;
        hold_left = 0;
        quiet_cycles = 0;
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;

        // defaults: first sample seeds the filter, encoder edges, homed edges
        send_word(13'd0, -16'sd32768, 25'sd0, 25'sd0);
        send_word(13'd4096, 16'sd0, 25'sd11796480, 25'sd16384000);
        send_word(13'd4097, 16'sd32767, -25'sd11796480, -25'sd16384000);
        send_word(13'd8191, 16'sd100, 25'sd11796480, 25'sd0);
        send_word(13'd68, 16'sd0, 25'sd0, 25'sd0);
        send_word(13'd69, 16'sd0, 25'sd0, 25'sd0);
        send_word(13'd8124, 16'sd0, 25'sd0, 25'sd0);
        send_word(13'd8123, -16'sd5, -25'sd16777216, 25'sd16777215);
        send_word(13'd0, 16'sd0, 25'sd16777215, 25'sd0);
        for (int k = 0; k < 5; k++)
            send_word(13'd2048, -16'sd32768, 25'sd11796480, 25'sd16384000);
        for (int k = 0; k < 4; k++)
            send_word(13'd6000, 16'sd32767, -25'sd11796480, -25'sd16384000);
        drain();

        // extremes: largest gains, zero at the top count, weight above one
        write_reg(REG_ZERO_POSITION, 24'd8191);
        for (int i = 1; i < 7; i++) write_reg(casp_reg_t'(i), 24'hFFFFFF);
        write_reg(REG_FILTER_WEIGHT, 24'h1FFFF);
        send_word(13'd4095, -16'sd32768, 25'sd11796480, 25'sd16384000);
        send_word(13'd4094, 16'sd32767, -25'sd11796480, -25'sd16384000);
        send_word(13'd8191, 16'sd0, 25'sd0, 25'sd0);
        ready_mode = 1;
        random_phase(100, 1'b1);
        drain();

        for (int i = 0; i < 8; i++) write_reg(casp_reg_t'(i), 24'd0);
        ready_mode = 2;
        random_phase(100, 1'b0);
        drain();

        write_reg(REG_ZERO_POSITION, 24'($urandom_range(0, 8191)));
        for (int i = 1; i < 7; i++) write_reg(casp_reg_t'(i), 24'($urandom));
        write_reg(REG_FILTER_WEIGHT, 24'($urandom_range(0, 131071)));
        ready_mode = 0;
        random_phase(110, 1'b0);
        drain();

        write_reg(REG_ZERO_POSITION, 24'($urandom));
        write_reg(REG_ANGLE_P_GAIN, 24'd393216);
        write_reg(REG_ANGLE_I_GAIN, 24'($urandom_range(0, 65536)));
        write_reg(REG_ANGLE_D_GAIN, 24'($urandom_range(0, 65536)));
        write_reg(REG_SPEED_P_GAIN, 24'($urandom_range(0, 6553600)));
        write_reg(REG_SPEED_I_GAIN, 24'($urandom_range(0, 65536)));
        write_reg(REG_SPEED_D_GAIN, 24'($urandom_range(0, 65536)));
        write_reg(REG_FILTER_WEIGHT, 24'd65536);
        ready_mode = 1;
        random_phase(110, 1'b0);
        drain();

        write_reg(REG_FILTER_WEIGHT, 24'($urandom_range(0, 65535)));
        ready_mode = 2;
        random_phase(110, 1'b0);
        drain();

        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire
